// ===== design/xt3_pkg.sv =====
// ----------------------------------------------------------------------------
// XTEA3 package
// Shared constants, types and round functions for the XTEA3 pipeline.
// ----------------------------------------------------------------------------
package xt3_pkg;

	localparam int XT3_ROUNDS   = 32;
	localparam int XT3_NUM_KEYS = 8;
	localparam int XT3_NUM_WORDS = 4;

	localparam logic [31:0] XT3_DELTA    = 32'h9E3779B9;
	localparam logic [63:0] XT3_SUM_PROD = 64'(XT3_DELTA) * 64'(XT3_ROUNDS);
	localparam logic [31:0] XT3_SUM_DEC  = XT3_SUM_PROD[31:0];

	typedef enum logic {
		MODE_DECRYPT = 1'b0,
		MODE_ENCRYPT = 1'b1
	} mode_t;

	typedef logic [XT3_NUM_KEYS-1:0][31:0] key_t;

	typedef struct packed {
		mode_t                           mode;
		logic [31:0]                     sum;
		logic [XT3_NUM_WORDS-1:0][31:0]  w;
	} xt3_state_t;

	function automatic logic [31:0] xt3_rotl(input logic [31:0] x, input logic [4:0] amt);
		logic [63:0] t;
		t = {x, x} << amt;
		return t[63:32];
	endfunction

	function automatic logic [31:0] xt3_mix(
		input logic [31:0] x,
		input logic [31:0] y,
		input logic [31:0] sum,
		input logic [31:0] k_hi,
		input logic [31:0] k_lo
	);
		logic [31:0] p;
		logic [31:0] q;
		p = (x << 4) + xt3_rotl(k_hi, x[4:0]);
		q = (x >> 5) + xt3_rotl(k_lo, x[31:27]);
		return p ^ (y + sum) ^ q;
	endfunction

endpackage

// ===== design/xtea3_block_cipher.sv =====
// ----------------------------------------------------------------------------
// XTEA3 block cipher, 128-bit block, 256-bit key
// An input transfer reaches out_valid through the entry register, the round stages and the output register.
// Throughput: one block per cycle while the output is not stalled; one pipeline stage per half-round.
// A stalled output holds the whole pipeline through a common enable.
// Reset clears the key registers and all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module xtea3_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] in_word0,
	input  logic [31:0] in_word1,
	input  logic [31:0] in_word2,
	input  logic [31:0] in_word3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_word0,
	output logic [31:0] out_word1,
	output logic [31:0] out_word2,
	output logic [31:0] out_word3
);
	import xt3_pkg::*;

	key_t                           key_q;
	logic                           en;
	logic [XT3_NUM_WORDS-1:0][31:0] in_w;
	xt3_state_t                     entry_nxt;
	xt3_state_t                     entry_s1;
	logic                           valid_s1;
	xt3_state_t                     rnd_st [XT3_ROUNDS+1];
	logic [XT3_ROUNDS:0]            rnd_valid;
	logic [XT3_NUM_WORDS-1:0][31:0] exit_nxt;
	logic [XT3_NUM_WORDS-1:0][31:0] out_w_q;
	logic                           out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;
	assign in_w     = {in_word3, in_word2, in_word1, in_word0};

	always_comb begin
		entry_nxt.mode = mode_t'(mode);
		if (mode_t'(mode) == MODE_ENCRYPT) begin
			entry_nxt.sum = '0;
			for (int i = 0; i < XT3_NUM_WORDS; i++) begin
				entry_nxt.w[i] = in_w[i] + key_q[3'(i)];
			end
		end else begin
			entry_nxt.sum = XT3_SUM_DEC;
			for (int i = 0; i < XT3_NUM_WORDS; i++) begin
				entry_nxt.w[i] = in_w[i] ^ key_q[3'(i + XT3_NUM_WORDS)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entry_s1 <= entry_nxt;
		end
	end

	assign rnd_st[0]    = entry_s1;
	assign rnd_valid[0] = valid_s1;

	for (genvar g = 0; g < XT3_ROUNDS; g++) begin : g_round
		xt3_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.key       (key_q),
			.in_valid  (rnd_valid[g]),
			.in_st     (rnd_st[g]),
			.out_valid (rnd_valid[g+1]),
			.out_st    (rnd_st[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < XT3_NUM_WORDS; i++) begin
			if (rnd_st[XT3_ROUNDS].mode == MODE_ENCRYPT) begin
				exit_nxt[i] = rnd_st[XT3_ROUNDS].w[i] ^ key_q[3'(i + XT3_NUM_WORDS)];
			end else begin
				exit_nxt[i] = rnd_st[XT3_ROUNDS].w[i] - key_q[3'(i)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= rnd_valid[XT3_ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_w_q <= exit_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word0 = out_w_q[0];
	assign out_word1 = out_w_q[1];
	assign out_word2 = out_w_q[2];
	assign out_word3 = out_w_q[3];

endmodule

// ===== design/xt3_round.sv =====
// ----------------------------------------------------------------------------
// XTEA3 round
// One full cipher round as two register stages, one half-round each.
// Both directions share the stages; the mode travels with the data.
// ----------------------------------------------------------------------------
module xt3_round (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  xt3_pkg::key_t      key,
	input  logic               in_valid,
	input  xt3_pkg::xt3_state_t in_st,
	output logic               out_valid,
	output xt3_pkg::xt3_state_t out_st
);
	import xt3_pkg::*;

	logic        valid_s1;
	logic        valid_s2;
	xt3_state_t  st_s1;
	xt3_state_t  st_s2;
	xt3_state_t  nxt_a;
	xt3_state_t  nxt_b;
	logic [31:0] x_a, y_a, f_a;
	logic [31:0] x_b, y_b, f_b;
	logic [1:0]  sel_a, sel_b;

	// first half: encrypt updates word 0, decrypt rotates then updates word 2
	always_comb begin
		nxt_a = in_st;
		if (in_st.mode == MODE_ENCRYPT) begin
			sel_a = in_st.sum[1:0];
			x_a   = in_st.w[1];
			y_a   = in_st.w[3];
		end else begin
			sel_a = in_st.sum[12:11];
			x_a   = in_st.w[2];
			y_a   = in_st.w[0];
		end
		f_a = xt3_mix(x_a, y_a, in_st.sum, key[{1'b1, sel_a}], key[{1'b0, sel_a}]);
		if (in_st.mode == MODE_ENCRYPT) begin
			nxt_a.w[0] = in_st.w[0] + f_a;
			nxt_a.sum  = in_st.sum + XT3_DELTA;
		end else begin
			nxt_a.w[0] = in_st.w[3];
			nxt_a.w[1] = in_st.w[0];
			nxt_a.w[2] = in_st.w[1] - f_a;
			nxt_a.w[3] = in_st.w[2];
			nxt_a.sum  = in_st.sum - XT3_DELTA;
		end
	end

	// second half: encrypt updates word 2 then rotates, decrypt updates word 0
	always_comb begin
		nxt_b = st_s1;
		if (st_s1.mode == MODE_ENCRYPT) begin
			sel_b = st_s1.sum[12:11];
			x_b   = st_s1.w[3];
			y_b   = st_s1.w[1];
		end else begin
			sel_b = st_s1.sum[1:0];
			x_b   = st_s1.w[1];
			y_b   = st_s1.w[3];
		end
		f_b = xt3_mix(x_b, y_b, st_s1.sum, key[{1'b1, sel_b}], key[{1'b0, sel_b}]);
		if (st_s1.mode == MODE_ENCRYPT) begin
			nxt_b.w[0] = st_s1.w[1];
			nxt_b.w[1] = st_s1.w[2] + f_b;
			nxt_b.w[2] = st_s1.w[3];
			nxt_b.w[3] = st_s1.w[0];
		end else begin
			nxt_b.w[0] = st_s1.w[0] - f_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nxt_a;
			st_s2 <= nxt_b;
		end
	end

	assign out_valid = valid_s2;
	assign out_st    = st_s2;

endmodule

// ===== design/xt3_checker.sv =====
// ----------------------------------------------------------------------------
// XTEA3 port checker
// Watches the cipher's ports for handshake and back-pressure behavior.
// ----------------------------------------------------------------------------
module xt3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] out_word0,
	input logic [31:0] out_word1,
	input logic [31:0] out_word2,
	input logic [31:0] out_word3
);

	a_stall_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not track a stalled output transfer");

	a_reset_no_output: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid after reset");

	a_output_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word0) && $stable(out_word1)
			&& $stable(out_word2) && $stable(out_word3))
		else $error("stalled output changed");

	a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");

endmodule

bind xtea3_block_cipher xt3_checker u_xt3_checker (.*);
